/* src/tdi_pkg.sv */
package tdi_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int FW_W      = 12;
    localparam int FH_W      = 16;
    localparam int THR_W     = 16;
    localparam int DIFF_W    = 19;
    localparam int SUM_W     = 16;
    localparam int ACC_W     = 20;
    // width compare domain: holds both the 12-bit register and MAX_WIDTH
    localparam int WID_W     = (ADDR_W + 1 > FW_W) ? ADDR_W + 1 : FW_W;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    localparam logic signed [ACC_W-1:0] SUM_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SUM_MIN = -ACC_W'(32768);

    localparam logic [FW_W-1:0]  FW_RESET  = FW_W'(2048);
    localparam logic [FH_W-1:0]  FH_RESET  = FH_W'(1024);
    localparam logic [THR_W-1:0] THR_RESET = '0;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_THRESH = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [FW_W-1:0]  frame_width;
        logic [FH_W-1:0]  frame_height;
        logic [THR_W-1:0] gate_threshold;
    } t_cfg;

    function automatic logic signed [SUM_W-1:0] sat16(input logic signed [ACC_W-1:0] x);
        logic signed [SUM_W-1:0] y;
        if (x > SUM_MAX) begin
            y = SUM_W'(SUM_MAX);
        end else if (x < SUM_MIN) begin
            y = SUM_W'(SUM_MIN);
        end else begin
            y = x[SUM_W-1:0];
        end
        return y;
    endfunction

endpackage

/* src/tdi_regs.sv */
module tdi_regs
    import tdi_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx sel;
    logic     wr_en;

    assign sel    = t_reg_idx'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width    <= FW_RESET;
            r_cfg.frame_height   <= FH_RESET;
            r_cfg.gate_threshold <= THR_RESET;
        end else if (wr_en) begin
            case (sel)
                REG_WIDTH:  r_cfg.frame_width    <= pwdata[FW_W-1:0];
                REG_HEIGHT: r_cfg.frame_height   <= pwdata[FH_W-1:0];
                REG_THRESH: r_cfg.gate_threshold <= pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_WIDTH:  prdata = PDATA_W'(r_cfg.frame_width);
            REG_HEIGHT: prdata = PDATA_W'(r_cfg.frame_height);
            REG_THRESH: prdata = PDATA_W'(r_cfg.gate_threshold);
            default:    prdata = '0;
        endcase
    end

endmodule

/* src/thresholded_2d_integrator.sv */
// Thresholded 2D integrator: rebuilds an integral image from a raster stream
// of second-derivative pixels.
// Input channel: i_valid / o_stall with i_diff_value, one pixel per beat in
// raster order. Output channel: o_valid / i_stall with o_sum_value and
// o_last_of_frame, one result per input beat, in order.
// Frame geometry and the gate threshold come from the APB registers
// (frame_width at 0x0, frame_height at 0x4, gate_threshold at 0x8); write them
// only while no pixel is in flight.
// An accepted pixel passes the compute stage (row buffer read at accept) and then
// the output register. Throughput is one pixel per cycle while the receiver does
// not stall, set by the row buffer with one read and one write port: one read
// at accept and one write of the result each cycle, with a bypass when both
// hit the same column.
// Reset clears the column and row counters and the left and up-left sums and
// restores the register defaults. The row buffer is not cleared: row 0 reads it
// but never uses the value.
// When the receiver stalls, the output register holds its beat and the
// compute stage holds one more; after that o_stall rises.
module thresholded_2d_integrator
    import tdi_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [DIFF_W-1:0] i_diff_value,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [SUM_W-1:0]  o_sum_value,
    output logic                     o_last_of_frame
);

    t_cfg cfg;

    tdi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // counters
    logic [ADDR_W-1:0] r_col, n_col;
    logic [FH_W-1:0]   r_row, n_row;

    // compute stage
    logic                     r_s1v;
    logic signed [DIFF_W-1:0] r_s1_diff;
    logic [ADDR_W-1:0]        r_s1_idx;
    logic                     r_s1_first;
    logic                     r_s1_row0;
    logic                     r_s1_col0;
    logic                     r_s1_last;
    logic                     r_s1_fwd;
    logic signed [SUM_W-1:0]  r_rdata;

    logic signed [SUM_W-1:0] r_left;
    logic signed [SUM_W-1:0] r_upleft;

    // output register
    logic                    r_ovalid;
    logic signed [SUM_W-1:0] r_osum;
    logic                    r_olast;

    logic signed [SUM_W-1:0] r_mem [MAX_WIDTH];

    logic accept;
    logic s1_move;

    logic [WID_W-1:0]  width;
    logic [WID_W-1:0]  col_ext;
    logic [WID_W-1:0]  col;
    logic [ADDR_W-1:0] idx;
    logic [FH_W-1:0]   height;
    logic              last_col;
    logic              last_row;

    logic signed [SUM_W-1:0] up;
    logic signed [ACC_W-1:0] diff_x;
    logic signed [ACC_W-1:0] mag;
    logic signed [ACC_W-1:0] pred;
    logic signed [ACC_W-1:0] acc;
    logic signed [SUM_W-1:0] result;

    assign s1_move = r_s1v && (!r_ovalid || !i_stall);
    assign o_stall = r_s1v && !s1_move;
    assign accept  = i_valid && !o_stall;

    // active geometry and position of the incoming pixel
    always_comb begin
        width = WID_W'(cfg.frame_width);
        if (width == '0) begin
            width = WID_W'(1);
        end else if (width > WID_W'(MAX_WIDTH)) begin
            width = WID_W'(MAX_WIDTH);
        end
        height  = (cfg.frame_height == '0) ? FH_W'(1) : cfg.frame_height;
        col_ext = WID_W'(r_col);
        col     = (col_ext >= width) ? width - WID_W'(1) : col_ext;
        idx     = col[ADDR_W-1:0];
        last_col = (col == width - WID_W'(1));
        last_row = ({1'b0, r_row} + (FH_W + 1)'(1)) >= {1'b0, height};
    end

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + FH_W'(1);
            end else begin
                n_col = idx + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // row buffer: read at accept, write when the result leaves the compute stage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_mem[r_s1_idx] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else if (accept) begin
            r_s1v <= 1'b1;
        end else if (s1_move) begin
            r_s1v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_diff  <= i_diff_value;
            r_s1_idx   <= idx;
            r_s1_row0  <= (r_row == '0);
            r_s1_col0  <= (col == '0);
            r_s1_first <= (r_row == '0) && (col == '0);
            r_s1_last  <= last_col && last_row;
            // same column written by the pixel leaving now: read saw stale data
            r_s1_fwd   <= r_s1v && (r_s1_idx == idx);
        end
    end

    always_comb begin
        up     = r_s1_fwd ? r_left : r_rdata;
        diff_x = ACC_W'(r_s1_diff);
        mag    = (diff_x < 0) ? -diff_x : diff_x;
        if (r_s1_row0) begin
            pred = ACC_W'(r_left);
        end else if (r_s1_col0) begin
            pred = ACC_W'(up);
        end else begin
            pred = ACC_W'(up) + ACC_W'(r_left) - ACC_W'(r_upleft);
        end
        if (r_s1_first) begin
            acc = diff_x;
        end else if (mag > ACC_W'(cfg.gate_threshold)) begin
            acc = pred + diff_x;
        end else begin
            acc = pred;
        end
        result = sat16(acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_upleft <= '0;
        end else if (s1_move) begin
            r_left   <= result;
            r_upleft <= up;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (s1_move) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_osum  <= result;
            r_olast <= r_s1_last;
        end
    end

    assign o_valid         = r_ovalid;
    assign o_sum_value     = r_osum;
    assign o_last_of_frame = r_olast;

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1v)
        else $error("accepted beat did not reach the compute stage");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1v && !s1_move |=> r_s1v && $stable(r_s1_diff) && $stable(r_s1_idx))
        else $error("compute stage lost or changed a held beat");

    a_ovalid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_s1v))
        else $error("output valid without a beat in the compute stage");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_s1v |-> s1_move)
        else $error("accepted beat while the compute stage was blocked");

endmodule

/* sim/integral_checker.sv */
module integral_checker
    import tdi_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic                     pready,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    input  logic                     i_valid,
    input  logic                     o_stall,
    input  logic signed [DIFF_W-1:0] i_diff_value,
    input  logic                     o_valid,
    input  logic                     i_stall,
    input  logic signed [SUM_W-1:0]  o_sum_value,
    input  logic                     o_last_of_frame,
    output int                       o_fail_count,
    output int                       o_results_seen
);

    localparam int SHOWN_FAILS = 40;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_pixel_out;

    t_cfg            cfg;
    int              col_cnt;
    logic [FH_W-1:0] row_cnt;
    int              left_sum;
    int              up_left_sum;
    int              row_sums [MAX_WIDTH];
    t_pixel_out      expected_sums [$];
    t_pixel_out      want;
    int              fails   = 0;
    int              matched = 0;

    function automatic int clamp_sum(int x);
        if (x > 32767) begin
            return 32767;
        end
        if (x < -32768) begin
            return -32768;
        end
        return x;
    endfunction

    // one raster step of the integral image rebuild
    function automatic t_pixel_out integrate_pixel(logic signed [DIFF_W-1:0] v);
        int         width;
        int         height;
        int         col;
        int         up;
        int         mag;
        int         acc;
        int         res;
        t_pixel_out r;
        width = (cfg.frame_width == '0) ? 1 : int'(cfg.frame_width);
        if (width > MAX_WIDTH) begin
            width = MAX_WIDTH;
        end
        height = (cfg.frame_height == '0) ? 1 : int'(cfg.frame_height);
        // a shrunk width ends the row on the current pixel
        col = (col_cnt >= width) ? width - 1 : col_cnt;
        up  = row_sums[col];
        acc = v;
        mag = (acc < 0) ? -acc : acc;
        if (row_cnt != '0 || col != 0) begin
            if (row_cnt == '0) begin
                acc = left_sum;
            end else if (col == 0) begin
                acc = up;
            end else begin
                acc = up + left_sum - up_left_sum;
            end
            if (mag > int'(cfg.gate_threshold)) begin
                acc = acc + int'(v);
            end
        end
        res           = clamp_sum(acc);
        r.sum         = SUM_W'(res);
        r.last        = (col + 1 >= width) && (int'(row_cnt) + 1 >= height);
        up_left_sum   = up;
        row_sums[col] = res;
        left_sum      = res;
        if (col + 1 >= width) begin
            col_cnt = 0;
            row_cnt = (int'(row_cnt) + 1 >= height) ? '0 : row_cnt + 1'b1;
        end else begin
            col_cnt = col + 1;
        end
        return r;
    endfunction

    task automatic flag(string what, int exp_val, int got_val);
        fails++;
        if (fails <= SHOWN_FAILS) begin
            $display("%0t: %s expected %0d got %0d", $time, what, exp_val, got_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg = '{frame_width: FW_RESET, frame_height: FH_RESET, gate_threshold: THR_RESET};
            col_cnt     = 0;
            row_cnt     = '0;
            left_sum    = 0;
            up_left_sum = 0;
            expected_sums.delete();
        end else begin
            // results leave only after passing the compute and output registers, so check before predicting
            if (o_valid && !i_stall) begin
                if (expected_sums.size() == 0) begin
                    fails++;
                    if (fails <= SHOWN_FAILS) begin
                        $display("%0t: result beat expected none got sum_value %0d",
                                 $time, o_sum_value);
                    end
                end else begin
                    want = expected_sums.pop_front();
                    matched++;
                    if (want.sum !== o_sum_value) begin
                        flag("sum_value", $signed(want.sum), $signed(o_sum_value));
                    end
                    if (want.last !== o_last_of_frame) begin
                        flag("last_of_frame", want.last, o_last_of_frame);
                    end
                end
            end
            if (i_valid && !o_stall) begin
                expected_sums.push_back(integrate_pixel(i_diff_value));
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[PADDR_W-1:2])
                    REG_WIDTH: begin
                        cfg.frame_width = pwdata[FW_W-1:0];
                    end
                    REG_HEIGHT: begin
                        cfg.frame_height = pwdata[FH_W-1:0];
                    end
                    REG_THRESH: begin
                        cfg.gate_threshold = pwdata[THR_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_fail_count   <= fails;
        o_results_seen <= matched;
    end

endmodule

/* sim/tb.sv */
module tb;
    import tdi_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_PIXELS = 300;
    localparam int TAIL_CYCLES   = 20;
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(12);

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idling;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     psel         = 1'b0;
    logic                     penable      = 1'b0;
    logic                     pwrite       = 1'b0;
    logic [PADDR_W-1:0]       paddr        = '0;
    logic [PDATA_W-1:0]       pwdata       = '0;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     i_valid      = 1'b0;
    logic                     o_stall;
    logic signed [DIFF_W-1:0] i_diff_value = '0;
    logic                     o_valid;
    logic                     i_stall      = 1'b0;
    logic signed [SUM_W-1:0]  o_sum_value;
    logic                     o_last_of_frame;
    int                       o_fail_count;
    int                       o_results_seen;

    int   pixels_sent   = 0;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    int   gate_level    = 0;
    int   cur_width     = MAX_WIDTH;
    int   hold_left     = 0;
    int   cycle_count   = 0;
    logic hold_armed    = 1'b0;
    logic hold_taken    = 1'b0;
    logic signed [DIFF_W-1:0] pixel_plan [$];

    always #1 i_clk = ~i_clk;

    thresholded_2d_integrator uut (.*);

    integral_checker chk (.*);

    // receiver side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (hold_armed && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            i_stall    <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic logic [PADDR_W-1:0] reg_addr(t_reg_idx r);
        return PADDR_W'({r, 2'b00});
    endfunction

    function automatic int active_width(int w);
        int a;
        a = w & 32'hFFF;
        if (a == 0) begin
            a = 1;
        end else if (a > MAX_WIDTH) begin
            a = MAX_WIDTH;
        end
        return a;
    endfunction

    function automatic logic signed [DIFF_W-1:0] next_pixel();
        int pick;
        int m;
        if (pixel_plan.size() > 0) begin
            return pixel_plan.pop_front();
        end
        pick = $urandom_range(99);
        if (pick < 40) begin
            m = $urandom_range(128);
            return DIFF_W'(m - 64);
        end else if (pick < 60) begin
            // straddle the gate: magnitude just below, at and above it
            m = gate_level - 1 + $urandom_range(2);
            if (m < 0) begin
                m = 0;
            end
            return $urandom_range(1) ? DIFF_W'(m) : DIFF_W'(-m);
        end else if (pick < 85) begin
            return DIFF_W'($urandom());
        end
        m = $urandom_range(80000);
        return DIFF_W'(m - 40000);
    endfunction

    task automatic set_idling(t_idling mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SENDER: begin
                send_idle_pct = 67;
                stall_pct     = 0;
            end
            IDLE_RECEIVER: begin
                send_idle_pct = 0;
                stall_pct     = 67;
            end
            default: begin
                send_idle_pct = 22;
                stall_pct     = 22;
            end
        endcase
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(t_reg_idx r, int value, bit junk_upper);
        logic [PDATA_W-1:0] data;
        data = PDATA_W'(value);
        if (junk_upper) begin
            data = data | ($urandom() << 16);
        end
        if (r == REG_THRESH) begin
            gate_level = value;
        end
        apb_write(reg_addr(r), data);
    endtask

    task automatic send_run(int count);
        logic signed [DIFF_W-1:0] v;
        for (int n = 0; n < count; n++) begin
            v = next_pixel();
            while ($urandom_range(99) < send_idle_pct) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
            i_valid      <= 1'b1;
            i_diff_value <= v;
            do @(posedge i_clk); while (o_stall);
            pixels_sent++;
        end
        i_valid <= 1'b0;
    endtask

    task automatic drain_results();
        do @(posedge i_clk); while (o_results_seen != pixels_sent);
    endtask

    task automatic set_width(int w, bit junk_upper);
        int eff;
        eff = active_width(w);
        // a row may only grow at a frame start, so row 0 fills the buffer first
        if (eff > cur_width) begin
            write_reg(REG_WIDTH, 1, 1'b0);
            write_reg(REG_HEIGHT, 1, 1'b0);
            send_run(1);
            drain_results();
        end
        write_reg(REG_WIDTH, w, junk_upper);
        cur_width = eff;
    endtask

    task automatic run_geometry(int w, int h, int thr, t_idling mode, int count);
        set_width(w, 1'b0);
        write_reg(REG_HEIGHT, h, 1'b0);
        write_reg(REG_THRESH, thr, 1'b0);
        set_idling(mode);
        send_run(count);
        drain_results();
    endtask

    initial begin
        int random_sent;
        int phase;
        int pick;
        int w;
        int h;
        int thr;
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset geometry: extremes of the input range saturate along row 0
        pixel_plan = '{-262144, 262143, 1, -1, 0, -32769, 32767, 32768,
                       -65536, 65535, 12, -7, 3};
        set_idling(IDLE_NONE);
        send_run(20);
        drain_results();

        // shrink mid-frame, gate right at its edge
        pixel_plan = '{1000, -1000, 1001, -1001, 999, 0, 262143, -262144, 1000, 2000};
        run_geometry(5, 3, 1000, IDLE_SENDER, 40);
        // zero width and height act as one pixel frames
        run_geometry(0, 0, 0, IDLE_RECEIVER, 20);
        // width above the buffer clamps to it
        run_geometry(4095, 0, 65535, IDLE_BOTH, 30);
        run_geometry(1, 65535, 7, IDLE_SENDER, 30);
        run_geometry(MAX_WIDTH, 2, 0, IDLE_RECEIVER, 25);

        // unmapped register, then a long receiver hold-off to back the block up
        apb_write(SPARE_ADDR, $urandom());
        hold_armed <= 1'b1;
        run_geometry(3, 4, 20, IDLE_NONE, 100);

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_PIXELS) begin
            if ($urandom_range(99) < 80) begin
                pick = $urandom_range(99);
                if (pick < 70) begin
                    w = $urandom_range(1, 8);
                end else if (pick < 90) begin
                    w = $urandom_range(9, 40);
                end else if (pick < 94) begin
                    w = 0;
                end else if (pick < 97) begin
                    w = MAX_WIDTH;
                end else begin
                    w = $urandom_range(4095);
                end
                set_width(w, 1'($urandom_range(1)));
            end
            if ($urandom_range(99) < 70) begin
                pick = $urandom_range(99);
                if (pick < 60) begin
                    h = $urandom_range(1, 5);
                end else if (pick < 80) begin
                    h = 0;
                end else begin
                    h = $urandom_range(65535);
                end
                write_reg(REG_HEIGHT, h, 1'($urandom_range(1)));
            end
            if ($urandom_range(99) < 60) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    thr = 0;
                end else if (pick < 70) begin
                    thr = $urandom_range(100);
                end else if (pick < 90) begin
                    thr = $urandom_range(65535);
                end else begin
                    thr = 65535;
                end
                write_reg(REG_THRESH, thr, 1'($urandom_range(1)));
            end
            if ($urandom_range(99) < 10) begin
                apb_write(SPARE_ADDR, $urandom());
            end
            set_idling(t_idling'(phase % 4));
            n = $urandom_range(20, 60);
            send_run(n);
            drain_results();
            random_sent += n;
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (o_fail_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

/* thresholded_2d_integrator.f */
src/tdi_pkg.sv
src/tdi_regs.sv
src/thresholded_2d_integrator.sv
sim/integral_checker.sv
sim/tb.sv
